@@ src/edge_clamped_box_blur_core_macros.svh @@
// assertion macros for the box blur core
// used by files that check their own logic; needs clk and rst_n in scope
`ifndef EDGE_CLAMPED_BOX_BLUR_CORE_MACROS_SVH
`define EDGE_CLAMPED_BOX_BLUR_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define ECBB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ECBB_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ECBB_ASSERT(lbl, prop, msg)
`define ECBB_NEVER(lbl, expr, msg)
`endif
`endif

@@ src/ecbb_pkg.sv @@
// shared types and constants for the box blur core
// no dependencies
package ecbb_pkg;
  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_RADIUS = 4;
  localparam int HEIGHT_LIMIT   = 4096;
  localparam int CFG_W_W   = 9;
  localparam int CFG_H_W   = 13;
  localparam int CFG_R_W   = 3;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W = 2;
  localparam int DIM_W     = 13;
  localparam int ROW_W     = 12;
  localparam int CNT_W     = 21;
  localparam int CRD_W     = 16;
  localparam int PIX_W     = 8;
  localparam int MEAN_W    = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_RADIUS = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    REQ_PIXEL = 1'b0,
    REQ_DRAIN = 1'b1
  } req_t;

  typedef struct packed {
    logic              done;
    logic [MEAN_W-1:0] quot;
  } div_res_t;
endpackage

@@ src/ecbb_if.sv @@
// channel interfaces for the box blur core
// depends on ecbb_pkg
interface ecbb_in_if;
  logic                      valid;
  logic                      ready;
  logic                      req_type;
  logic [ecbb_pkg::PIX_W-1:0] pixel;
  modport source (output valid, output req_type, output pixel, input ready);
  modport sink (input valid, input req_type, input pixel, output ready);
endinterface

interface ecbb_out_if;
  logic                       valid;
  logic                       ready;
  logic [ecbb_pkg::MEAN_W-1:0] mean_q8_8;
  logic                       last_of_frame;
  modport source (output valid, output mean_q8_8, output last_of_frame, input ready);
  modport sink (input valid, input mean_q8_8, input last_of_frame, output ready);
endinterface

@@ src/ecbb_ram.sv @@
// generic simple dual port ram, registered read
// no dependencies
module ecbb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ src/ecbb_div.sv @@
// restoring divider, one quotient bit per cycle
// depends on ecbb_pkg
module ecbb_div #(
  parameter int NW = 25,
  parameter int DW = 7
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [NW-1:0]         num,
  input  logic [DW-1:0]         den,
  output ecbb_pkg::div_res_t    res
);
  import ecbb_pkg::*;

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] num_r, num_nxt;
  logic [NW-1:0] quot_r, quot_nxt;
  logic [DW-1:0] den_r, den_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [DW:0]   trial;

  always_comb begin
    num_nxt  = num_r;
    quot_nxt = quot_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, num_r[NW-1]};
    if (start) begin
      num_nxt  = num;
      den_nxt  = den;
      rem_nxt  = '0;
      cnt_nxt  = CW'(NW - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      num_nxt = {num_r[NW-2:0], 1'b0};
      if (trial >= {1'b0, den_r}) begin
        rem_nxt  = DW'(trial - {1'b0, den_r});
        quot_nxt = {quot_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt  = trial[DW-1:0];
        quot_nxt = {quot_r[NW-2:0], 1'b0};
      end
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r  <= num_nxt;
    quot_r <= quot_nxt;
    den_r  <= den_nxt;
    rem_r  <= rem_nxt;
  end

  assign res.done = done_r;
  assign res.quot = quot_r[MEAN_W-1:0];
endmodule

@@ src/edge_clamped_box_blur_core.sv @@
// Box blur over an 8-bit depth frame with clamp-to-edge windows, Q8.8 mean
// output. Pixels are stored in a ring of 2*MAX_RADIUS+2 rows in one line
// memory. An item is accepted only in the idle state; an item that yields a
// result then reads its window samples from the line memory one per cycle
// (the single read port sets this rate), runs a one-bit-per-cycle divide,
// and holds the result until taken; no new item is accepted meanwhile.
// Results lag the input by min(r,H-1)*W + min(r,W-1) items;
// that many drain items flush the tail.
// Depends on ecbb_pkg, ecbb_if, ecbb_ram and ecbb_div.
`include "edge_clamped_box_blur_core_macros.svh"
module edge_clamped_box_blur_core #(
  parameter int MAX_WIDTH  = ecbb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_RADIUS = ecbb_pkg::DEF_MAX_RADIUS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  ecbb_in_if.sink                         in_ch,
  ecbb_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [ecbb_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [ecbb_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import ecbb_pkg::*;

  localparam int RING   = 2 * MAX_RADIUS + 2;
  localparam int DEPTH  = RING * MAX_WIDTH;
  localparam int AW     = $clog2(DEPTH);
  localparam int CW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int SW     = $clog2(RING);
  localparam int RW     = $clog2(MAX_RADIUS + 1);
  localparam int SUM_W  = $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) * 255 + 1);
  localparam int NW     = SUM_W + 10;
  localparam int DW     = 2 * RW + 3;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_READ = 5'b00010,
    S_DIV  = 5'b00100,
    S_OUT  = 5'b01000,
    S_WAIT = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [CFG_W_W-1:0] cfg_width_r;
  logic [CFG_H_W-1:0] cfg_height_r;
  logic [CFG_R_W-1:0] cfg_radius_r;

  logic [CNT_W-1:0] items_r, items_nxt;
  logic [CNT_W-1:0] og_r, og_nxt;
  logic [CW-1:0]    in_col_r, in_col_nxt;
  logic [SW-1:0]    in_slot_r, in_slot_nxt;
  logic [CW-1:0]    x_r, x_nxt;
  logic [ROW_W-1:0] y_r, y_nxt;
  logic [SW-1:0]    out_slot_r, out_slot_nxt;
  logic [RW:0]      dxi_r, dxi_nxt, dyi_r, dyi_nxt;
  logic             iss_r, iss_nxt;
  logic             rd_vld_r, rd_last_r;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [MEAN_W-1:0] mean_r, mean_nxt;
  logic             last_r, last_nxt;

  logic [DIM_W-1:0]   w, h, wm1, hm1, rv, rh;
  logic [RW-1:0]      r;
  logic [RW:0]        two_r, wsz;
  logic [2*RW+1:0]    dsq;
  logic [2*DIM_W-1:0] prod, lagp;
  logic [CNT_W-1:0]   n, lag;
  logic [CNT_W:0]     fire_lhs;

  logic signed [CRD_W-1:0] xs, ys, yc, off, stmp;
  logic [CW-1:0]    cx;
  logic [SW-1:0]    rslot;
  logic [AW-1:0]    raddr, waddr;
  logic             we;
  logic [PIX_W-1:0] rdata;
  logic [SUM_W-1:0] total;
  logic             div_start;
  logic [NW-1:0]    div_num;
  div_res_t         div_res;
  logic             in_acc, out_acc, is_pix, last_iss, clear;
  logic             cfg_hit;

  // saturated configuration
  always_comb begin
    if (cfg_width_r == '0) begin
      w = DIM_W'(1);
    end else if (DIM_W'(cfg_width_r) > DIM_W'(MAX_WIDTH)) begin
      w = DIM_W'(MAX_WIDTH);
    end else begin
      w = DIM_W'(cfg_width_r);
    end
    if (cfg_height_r == '0) begin
      h = DIM_W'(1);
    end else if (DIM_W'(cfg_height_r) > DIM_W'(HEIGHT_LIMIT)) begin
      h = DIM_W'(HEIGHT_LIMIT);
    end else begin
      h = DIM_W'(cfg_height_r);
    end
    if (32'(cfg_radius_r) > MAX_RADIUS) begin
      r = RW'(MAX_RADIUS);
    end else begin
      r = RW'(cfg_radius_r);
    end
    wm1   = w - DIM_W'(1);
    hm1   = h - DIM_W'(1);
    rv    = (DIM_W'(r) < hm1) ? DIM_W'(r) : hm1;
    rh    = (DIM_W'(r) < wm1) ? DIM_W'(r) : wm1;
    prod  = {{DIM_W{1'b0}}, w} * {{DIM_W{1'b0}}, h};
    n     = prod[CNT_W-1:0];
    lagp  = {{DIM_W{1'b0}}, rv} * {{DIM_W{1'b0}}, w} + {{DIM_W{1'b0}}, rh};
    lag   = lagp[CNT_W-1:0];
    two_r = {r, 1'b0};
    wsz   = two_r + (RW+1)'(1);
    dsq   = {{(RW+1){1'b0}}, wsz} * {{(RW+1){1'b0}}, wsz};
  end

  // window read address with clamped coordinates
  always_comb begin
    xs = $signed(CRD_W'(x_r)) + $signed(CRD_W'(dxi_r)) - $signed(CRD_W'(r));
    if (xs < 0) begin
      cx = '0;
    end else if (xs > $signed(CRD_W'(wm1))) begin
      cx = wm1[CW-1:0];
    end else begin
      cx = xs[CW-1:0];
    end
    ys = $signed(CRD_W'(y_r)) + $signed(CRD_W'(dyi_r)) - $signed(CRD_W'(r));
    if (ys < 0) begin
      yc = '0;
    end else if (ys > $signed(CRD_W'(hm1))) begin
      yc = $signed(CRD_W'(hm1));
    end else begin
      yc = ys;
    end
    off  = yc - $signed(CRD_W'(y_r));
    stmp = $signed(CRD_W'(out_slot_r)) + off;
    if (stmp < 0) begin
      stmp = stmp + CRD_W'(RING);
    end else if (stmp >= $signed(CRD_W'(RING))) begin
      stmp = stmp - CRD_W'(RING);
    end
    rslot = stmp[SW-1:0];
    raddr = AW'(32'(rslot) * MAX_WIDTH + 32'(cx));
    waddr = AW'(32'(in_slot_r) * MAX_WIDTH + 32'(in_col_r));
  end

  assign in_ch.ready   = (state_r == S_IDLE);
  assign in_acc        = in_ch.valid && in_ch.ready;
  assign is_pix        = (in_ch.req_type == REQ_PIXEL);
  assign out_ch.valid  = (state_r == S_OUT);
  assign out_acc       = out_ch.valid && out_ch.ready;
  assign out_ch.mean_q8_8     = mean_r;
  assign out_ch.last_of_frame = last_r;
  assign we       = in_acc && is_pix && (items_r < n);
  assign last_iss = (dxi_r == two_r) && (dyi_r == two_r);
  assign total    = sum_r + SUM_W'(rdata);
  assign div_start = (state_r == S_READ) && rd_last_r;
  assign div_num  = {total, 9'b0} + NW'(dsq);
  assign fire_lhs = {1'b0, og_r} + {1'b0, lag};
  assign cfg_hit  = cfg_we && (cfg_idx inside {REG_WIDTH, REG_HEIGHT, REG_RADIUS});

  always_comb begin
    state_nxt    = state_r;
    items_nxt    = items_r;
    og_nxt       = og_r;
    in_col_nxt   = in_col_r;
    in_slot_nxt  = in_slot_r;
    x_nxt        = x_r;
    y_nxt        = y_r;
    out_slot_nxt = out_slot_r;
    dxi_nxt      = dxi_r;
    dyi_nxt      = dyi_r;
    iss_nxt      = iss_r;
    sum_nxt      = sum_r;
    mean_nxt     = mean_r;
    last_nxt     = last_r;
    clear        = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (we) begin
            items_nxt = items_r + CNT_W'(1);
            if (DIM_W'(in_col_r) == wm1) begin
              in_col_nxt  = '0;
              in_slot_nxt = (in_slot_r == SW'(RING - 1)) ? '0 : in_slot_r + SW'(1);
            end else begin
              in_col_nxt = in_col_r + CW'(1);
            end
            if (fire_lhs < {1'b0, items_nxt}) begin
              state_nxt = S_READ;
            end
          end else if ((items_r >= n) && (og_r < n)) begin
            state_nxt = S_READ;
          end
          dxi_nxt = '0;
          dyi_nxt = '0;
          iss_nxt = 1'b1;
          sum_nxt = '0;
        end
      end
      S_READ: begin
        if (iss_r) begin
          if (dyi_r == two_r) begin
            dyi_nxt = '0;
            dxi_nxt = dxi_r + (RW+1)'(1);
          end else begin
            dyi_nxt = dyi_r + (RW+1)'(1);
          end
          if (last_iss) begin
            iss_nxt = 1'b0;
          end
        end
        if (rd_vld_r) begin
          sum_nxt = total;
        end
        if (rd_last_r) begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_res.done) begin
          mean_nxt  = div_res.quot;
          last_nxt  = (og_r == n - CNT_W'(1));
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_acc) begin
          og_nxt = og_r + CNT_W'(1);
          if (DIM_W'(x_r) == wm1) begin
            x_nxt        = '0;
            y_nxt        = y_r + ROW_W'(1);
            out_slot_nxt = (out_slot_r == SW'(RING - 1)) ? '0 : out_slot_r + SW'(1);
          end else begin
            x_nxt = x_r + CW'(1);
          end
          if (og_nxt == n) begin
            clear = 1'b1;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (clear || cfg_hit) begin
      items_nxt    = '0;
      og_nxt       = '0;
      in_col_nxt   = '0;
      in_slot_nxt  = '0;
      x_nxt        = '0;
      y_nxt        = '0;
      out_slot_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cfg_width_r  <= CFG_W_W'(240);
      cfg_height_r <= CFG_H_W'(160);
      cfg_radius_r <= CFG_R_W'(4);
      items_r      <= '0;
      og_r         <= '0;
      in_col_r     <= '0;
      in_slot_r    <= '0;
      x_r          <= '0;
      y_r          <= '0;
      out_slot_r   <= '0;
      iss_r        <= 1'b0;
      rd_vld_r     <= 1'b0;
      rd_last_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      items_r    <= items_nxt;
      og_r       <= og_nxt;
      in_col_r   <= in_col_nxt;
      in_slot_r  <= in_slot_nxt;
      x_r        <= x_nxt;
      y_r        <= y_nxt;
      out_slot_r <= out_slot_nxt;
      iss_r      <= iss_nxt;
      rd_vld_r   <= (state_r == S_READ) && iss_r;
      rd_last_r  <= (state_r == S_READ) && iss_r && last_iss;
      if (cfg_we) begin
        case (cfg_idx)
          REG_WIDTH:  cfg_width_r  <= cfg_wdata[CFG_W_W-1:0];
          REG_HEIGHT: cfg_height_r <= cfg_wdata[CFG_H_W-1:0];
          REG_RADIUS: cfg_radius_r <= cfg_wdata[CFG_R_W-1:0];
          default: begin
          end
        endcase
      end
    end
    dxi_r  <= dxi_nxt;
    dyi_r  <= dyi_nxt;
    sum_r  <= sum_nxt;
    mean_r <= mean_nxt;
    last_r <= last_nxt;
  end

  ecbb_ram #(
    .WIDTH(PIX_W),
    .DEPTH(DEPTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (in_ch.pixel),
    .raddr (raddr),
    .rdata (rdata)
  );

  ecbb_div #(
    .NW(NW),
    .DW(DW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   ({dsq, 1'b0}),
    .res   (div_res)
  );

  `ECBB_ASSERT(a_out_not_ahead, og_r <= items_r, "results ahead of taken pixels")
  `ECBB_ASSERT(a_items_bound, items_r <= n, "pixel count beyond frame size")
  `ECBB_ASSERT(a_div_done_state, div_res.done |-> state_r == S_DIV, "divide done outside divide state")
  `ECBB_NEVER(a_last_no_issue, rd_last_r && iss_r, "window reads still issuing after last")
endmodule

@@ dv/edge_clamped_box_blur_core_test.sv @@
// testbench for edge_clamped_box_blur_core: directed and random frames checked
// against a behavioral box blur predictor; depends on ecbb_pkg, ecbb_if and the core
module edge_clamped_box_blur_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ecbb_pkg::*;

  localparam int RING_ROWS = 2 * DEF_MAX_RADIUS + 2;
  localparam int SETTLE_CYCLES = 200;
  localparam longint CYCLE_LIMIT = 3000000;

  typedef struct {
    bit [MEAN_W-1:0] mean;
    bit              last;
  } blur_result_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  ecbb_in_if  in_ch();
  ecbb_out_if out_ch();

  edge_clamped_box_blur_core dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  // predictor state
  bit [7:0] row_ring [RING_ROWS][DEF_MAX_WIDTH];
  bit [CFG_W_W-1:0] width_reg;
  bit [CFG_H_W-1:0] height_reg;
  bit [CFG_R_W-1:0] radius_reg;
  int unsigned pixels_in;
  int unsigned means_out;

  blur_result_t expected_means[$];
  int error_count;
  int items_sent;
  longint cycle_count;
  bit quiet;
  int hold_cycles;

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic int clamp_int(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int eff_width();
    return clamp_int(width_reg, 1, DEF_MAX_WIDTH);
  endfunction

  function automatic int eff_height();
    return clamp_int(height_reg, 1, HEIGHT_LIMIT);
  endfunction

  function automatic int eff_radius();
    return (radius_reg > DEF_MAX_RADIUS) ? DEF_MAX_RADIUS : radius_reg;
  endfunction

  function automatic int frame_lag();
    int w, h, r;
    w = eff_width();
    h = eff_height();
    r = eff_radius();
    return ((r < h - 1) ? r : h - 1) * w + ((r < w - 1) ? r : w - 1);
  endfunction

  function automatic blur_result_t window_mean(int unsigned k);
    int w, h, r, x, y, d;
    int unsigned total;
    blur_result_t res;
    w = eff_width();
    h = eff_height();
    r = eff_radius();
    y = k / w;
    x = k % w;
    total = 0;
    for (int dy = -r; dy <= r; dy++)
      for (int dx = -r; dx <= r; dx++)
        total += row_ring[clamp_int(y + dy, 0, h - 1) % RING_ROWS][clamp_int(x + dx, 0, w - 1)];
    d = (2 * r + 1) * (2 * r + 1);
    res.mean = MEAN_W'((total * 512 + d) / (2 * d));
    res.last = (k == w * h - 1);
    return res;
  endfunction

  // advance the predictor by one accepted transaction
  function automatic void predict_blur(req_t req, bit [7:0] pix);
    int unsigned w, n;
    bit fire;
    w = eff_width();
    n = w * eff_height();
    fire = 1'b0;
    if (means_out >= n) begin
      pixels_in = 0;
      means_out = 0;
    end
    if (req == REQ_PIXEL && pixels_in < n) begin
      row_ring[(pixels_in / w) % RING_ROWS][pixels_in % w] = pix;
      pixels_in++;
      fire = means_out + frame_lag() < pixels_in;
    end else if (pixels_in >= n && means_out < n) begin
      fire = 1'b1;
    end
    if (fire) begin
      expected_means.push_back(window_mean(means_out));
      means_out++;
      if (means_out >= n) begin
        pixels_in = 0;
        means_out = 0;
      end
    end
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
    error_count++;
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // result checker
  always @(posedge clk) begin
    blur_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_means.size() == 0) begin
        report_mismatch("unexpected transaction", out_ch.mean_q8_8, -1);
      end else begin
        want = expected_means.pop_front();
        if (out_ch.mean_q8_8 !== want.mean) report_mismatch("mean_q8_8", out_ch.mean_q8_8, want.mean);
        if (out_ch.last_of_frame !== want.last)
          report_mismatch("last_of_frame", out_ch.last_of_frame, want.last);
      end
    end
  end

  // receiver with random stalls and an optional long hold
  initial begin
    forever begin
      if (hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
      if (!quiet && $urandom_range(0, 2) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
    end
  end

  task automatic send_item(req_t req, bit [7:0] pix);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.req_type <= req;
    in_ch.pixel <= pix;
    do @(posedge clk); while (!in_ch.ready);
    predict_blur(req, pix);
    items_sent++;
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (expected_means.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, bit [CFG_DATA_W-1:0] value);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_WIDTH:  width_reg = value[CFG_W_W-1:0];
      REG_HEIGHT: height_reg = value[CFG_H_W-1:0];
      default:    radius_reg = value[CFG_R_W-1:0];
    endcase
    pixels_in = 0;
    means_out = 0;
  endtask

  task automatic set_frame(int w, int h, int r);
    write_reg(REG_WIDTH, CFG_DATA_W'(w));
    write_reg(REG_HEIGHT, CFG_DATA_W'(h));
    write_reg(REG_RADIUS, CFG_DATA_W'(r));
  endtask

  task automatic send_pixels(int count);
    repeat (count) send_item(REQ_PIXEL, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_drains(int count);
    repeat (count) send_item(REQ_DRAIN, 8'($urandom_range(0, 255)));
  endtask

  task automatic test_defaults();
    send_pixels(20);
    wait_idle();
  endtask

  task automatic test_small_frames();
    set_frame(3, 3, 1);
    send_item(REQ_PIXEL, 8'd0);
    send_item(REQ_DRAIN, 8'd0);
    send_item(REQ_PIXEL, 8'd255);
    send_item(REQ_PIXEL, 8'd255);
    send_item(REQ_PIXEL, 8'd0);
    send_item(REQ_PIXEL, 8'd255);
    send_item(REQ_PIXEL, 8'd255);
    send_item(REQ_PIXEL, 8'd255);
    send_item(REQ_PIXEL, 8'd1);
    send_item(REQ_PIXEL, 8'd128);
    send_item(REQ_PIXEL, 8'd170);
    send_item(REQ_PIXEL, 8'd85);
    send_drains(3);
    send_item(REQ_DRAIN, 8'd255);
    set_frame(1, 1, 0);
    send_item(REQ_PIXEL, 8'd255);
    send_item(REQ_PIXEL, 8'd0);
    set_frame(0, 0, 7);
    send_item(REQ_PIXEL, 8'd77);
  endtask

  task automatic test_saturated_sizes();
    set_frame(511, 2, 7);
    send_pixels(280);
    set_frame(1, 8191, 6);
    send_pixels(12);
    set_frame(256, 4096, 4);
    send_pixels(4);
  endtask

  task automatic run_frame(bit allow_abort);
    int w, h, r, n, lag;
    w = $urandom_range(0, 9) == 0 ? $urandom_range(17, 64) : $urandom_range(1, 16);
    h = $urandom_range(1, 8);
    r = $urandom_range(0, 7);
    set_frame(w, h, r);
    n = eff_width() * eff_height();
    lag = frame_lag();
    if (allow_abort && $urandom_range(0, 9) == 0) begin
      send_pixels($urandom_range(1, n));
      return;
    end
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 19) == 0) send_item(REQ_DRAIN, 8'($urandom_range(0, 255)));
      send_item(REQ_PIXEL, 8'($urandom_range(0, 255)));
    end
    for (int i = 0; i < lag; i++)
      send_item($urandom_range(0, 4) == 0 ? REQ_PIXEL : REQ_DRAIN, 8'($urandom_range(0, 255)));
    if ($urandom_range(0, 3) == 0) send_drains($urandom_range(1, 3));
  endtask

  task automatic test_random_frames(int target);
    while (items_sent < target) run_frame(1'b1);
  endtask

  task automatic test_backpressure();
    set_frame(8, 6, 1);
    hold_cycles = 800;
    send_pixels(48);
    send_drains(9);
    wait_idle();
    send_pixels(30);
    send_drains(18);
  endtask

  task automatic test_quiet_tail(int target);
    quiet = 1'b1;
    while (items_sent < target) run_frame(1'b0);
  endtask

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_idx <= REG_WIDTH;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.req_type <= REQ_PIXEL;
    in_ch.pixel <= '0;
    error_count = 0;
    items_sent = 0;
    quiet = 1'b0;
    hold_cycles = 0;
    width_reg = 240;
    height_reg = 160;
    radius_reg = 4;
    pixels_in = 0;
    means_out = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_defaults();
    test_small_frames();
    test_saturated_sizes();
    test_random_frames(1000);
    test_backpressure();
    test_quiet_tail(1400);
    wait_idle();
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
